>>> rtl/core/wave_channel_playback_top_macros.svh
// assertion macros for the wave channel playback block
// used by the top level only; expects clk and arst_n in scope
`ifndef WAVE_CHANNEL_PLAYBACK_TOP_MACROS_SVH
`define WAVE_CHANNEL_PLAYBACK_TOP_MACROS_SVH

// same-cycle implication
`define WCP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WCP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/wcp_pkg.sv
// shared types and constants of the wave channel playback block
// no dependencies
`default_nettype none

package wcp_pkg;

	localparam int OP_W     = 2;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 8;
	localparam int SMP_W    = 4;
	localparam int RATE_W   = 18;
	localparam int FREQ_W   = 11;
	localparam int PERIOD_W = 12;
	localparam int LEN_W    = 9;
	localparam int VOL_W    = 2;
	localparam int CNT_W    = 32;
	localparam int CLK_W    = 23;
	localparam int PROD_W   = CNT_W + CLK_W;
	localparam int DEN_SHIFT = 6;
	localparam int DEN_W    = RATE_W + PERIOD_W + DEN_SHIFT;

	localparam logic [CLK_W-1:0]    PHASE_CLOCK = 23'd4195304;
	localparam logic [PERIOD_W-1:0] PERIOD_BASE = 12'd2048;
	localparam logic [LEN_W-1:0]    LEN_BASE    = 9'd256;
	localparam logic [RATE_W-1:0]   RATE_RESET  = 18'd44100;

	// operation codes
	localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
	localparam logic [OP_W-1:0] OP_READ   = 2'd1;
	localparam logic [OP_W-1:0] OP_FRAME  = 2'd2;
	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd3;

	// register addresses
	localparam logic [ADDR_W-1:0] ADDR_ENABLE  = 5'd0;
	localparam logic [ADDR_W-1:0] ADDR_LENGTH  = 5'd1;
	localparam logic [ADDR_W-1:0] ADDR_VOLUME  = 5'd2;
	localparam logic [ADDR_W-1:0] ADDR_FREQ_LO = 5'd3;
	localparam logic [ADDR_W-1:0] ADDR_FREQ_HI = 5'd4;
	localparam logic [ADDR_W-1:0] ADDR_LEN_EN  = 5'd5;
	localparam logic [ADDR_W-1:0] ADDR_RESTART = 5'd6;

	typedef struct packed {
		logic load;
		logic mul;
		logic scale;
		logic div_start;
		logic commit;
	} cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/wcp_div.sv
// bit-serial restoring divider returning the quotient modulo the wave length
// depends on nothing outside this file
`default_nettype none

module wcp_div #(
	parameter int NUM_W   = 61,
	parameter int DEN_W   = 36,
	parameter int MOD_VAL = 32
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire  [NUM_W-1:0]            num,
	input  wire  [DEN_W-1:0]            den,
	output logic                        busy,
	output logic [$clog2(MOD_VAL)-1:0]  index
);

	localparam int QW  = $clog2(MOD_VAL);
	localparam int CW  = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [QW-1:0]    qm_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;

	logic [DEN_W:0]   trial;
	logic             ge;
	logic [DEN_W:0]   diff;
	logic [QW:0]      qt;
	logic [QW-1:0]    qm_next;

	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
		// quotient kept reduced modulo the wave length, one bit at a time
		qt    = {qm_q, ge};
		if (qt >= (QW+1)'(MOD_VAL)) begin
			qm_next = QW'(qt - (QW+1)'(MOD_VAL));
		end else begin
			qm_next = qt[QW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			qm_q  <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			qm_q  <= qm_next;
		end
	end

	assign busy  = busy_q;
	assign index = qm_q;

endmodule

`default_nettype wire

>>> rtl/core/wcp_dp.sv
// datapath: channel registers, wave rows, phase products, divider, result register
// depends on wcp_pkg and wcp_div
`default_nettype none

module wcp_dp #(
	parameter int WAVE_SAMPLES = 32
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wcp_pkg::cmd_t                    cmd,
	output logic                             div_busy,
	input  wire  [wcp_pkg::OP_W-1:0]         op,
	input  wire  [wcp_pkg::ADDR_W-1:0]       addr,
	input  wire  [wcp_pkg::DATA_W-1:0]       data,
	input  wire                              sample_rate_we,
	input  wire  [wcp_pkg::RATE_W-1:0]       sample_rate,
	output logic [wcp_pkg::DATA_W-1:0]       read_data,
	output logic [wcp_pkg::SMP_W-1:0]        sample,
	output logic                             channel_on
);

	localparam int QW    = $clog2(WAVE_SAMPLES);
	localparam int HALF  = (WAVE_SAMPLES + 1) / 2;
	localparam int ROWS  = (HALF > 16) ? 16 : HALF;
	localparam int RW    = $clog2(ROWS);
	localparam int NUM_W = wcp_pkg::PROD_W + $clog2(WAVE_SAMPLES + 1);
	localparam int DEN_W = wcp_pkg::DEN_W;
	localparam int MUL_W = wcp_pkg::RATE_W + wcp_pkg::PERIOD_W;

	// item capture
	logic [wcp_pkg::OP_W-1:0]   op_q;
	logic [wcp_pkg::ADDR_W-1:0] addr_q;
	logic [wcp_pkg::DATA_W-1:0] data_q;

	// channel state
	logic                        enable_q;
	logic [wcp_pkg::LEN_W-1:0]   length_q;
	logic [wcp_pkg::VOL_W-1:0]   volume_q;
	logic [wcp_pkg::FREQ_W-1:0]  freq_q;
	logic                        len_en_q;
	logic [wcp_pkg::CNT_W-1:0]   count_q;
	logic [wcp_pkg::RATE_W-1:0]  rate_q;
	logic [wcp_pkg::DATA_W-1:0]  wave_q [ROWS];

	// phase products
	logic [wcp_pkg::PROD_W-1:0]  prod_s1;
	logic [DEN_W-1:0]            den_s1;
	logic [NUM_W-1:0]            num_s2;
	logic [DEN_W-1:0]            den_s2;

	// result register
	logic [wcp_pkg::DATA_W-1:0]  rd_q;
	logic [wcp_pkg::SMP_W-1:0]   smp_q;
	logic                        on_q;

	logic [QW-1:0]               index;
	logic [wcp_pkg::RATE_W-1:0]  rate_eff;
	logic [wcp_pkg::PERIOD_W-1:0] period;
	logic [MUL_W-1:0]            den_prod;
	logic [wcp_pkg::DATA_W-1:0]  row_byte;
	logic [wcp_pkg::SMP_W-1:0]   nib;
	logic [wcp_pkg::SMP_W-1:0]   smp_val;
	logic [wcp_pkg::DATA_W-1:0]  rd_val;
	logic                        en_next;
	logic [wcp_pkg::LEN_W-1:0]   len_dec;
	logic [3:0]                  wave_row;
	logic                        wave_hit;

	wcp_div #(
		.NUM_W   (NUM_W),
		.DEN_W   (DEN_W),
		.MOD_VAL (WAVE_SAMPLES)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_s2),
		.den    (den_s2),
		.busy   (div_busy),
		.index  (index)
	);

	always_comb begin
		rate_eff = (rate_q == '0) ? wcp_pkg::RATE_W'(1) : rate_q;
		period   = wcp_pkg::PERIOD_BASE - {1'b0, freq_q};
		den_prod = MUL_W'(rate_eff) * MUL_W'(period);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op;
			addr_q <= addr;
			data_q <= data;
		end
		if (cmd.mul) begin
			prod_s1 <= wcp_pkg::PROD_W'(count_q) * wcp_pkg::PROD_W'(wcp_pkg::PHASE_CLOCK);
			den_s1  <= {den_prod, {wcp_pkg::DEN_SHIFT{1'b0}}};
		end
		if (cmd.scale) begin
			num_s2 <= NUM_W'(prod_s1) * NUM_W'(WAVE_SAMPLES);
			den_s2 <= den_s1;
		end
	end

	// wave lookup: entries past the stored rows read as zero
	always_comb begin
		row_byte = wave_q[index[RW:1]];
		if ({1'b0, index} < (QW+1)'(2 * ROWS)) begin
			nib = index[0] ? row_byte[3:0] : row_byte[7:4];
		end else begin
			nib = '0;
		end
		if (volume_q == '0 || !enable_q) begin
			smp_val = '0;
		end else begin
			smp_val = nib >> (volume_q - wcp_pkg::VOL_W'(1));
		end
	end

	always_comb begin
		wave_row = addr_q[3:0];
		wave_hit = addr_q[4] && (int'(wave_row) < ROWS);
		len_dec  = (length_q != '0) ? length_q - wcp_pkg::LEN_W'(1) : length_q;
		en_next  = enable_q;
		rd_val   = '0;
		case (op_q)
			wcp_pkg::OP_WRITE: begin
				if (addr_q == wcp_pkg::ADDR_ENABLE) begin
					en_next = data_q != '0;
				end
			end
			wcp_pkg::OP_READ: begin
				unique case (addr_q)
					wcp_pkg::ADDR_ENABLE: rd_val = {7'd0, enable_q};
					wcp_pkg::ADDR_VOLUME: rd_val = {1'b0, volume_q, 5'd0};
					wcp_pkg::ADDR_LEN_EN: rd_val = {7'd0, len_en_q};
					default:              rd_val = '0;
				endcase
			end
			wcp_pkg::OP_FRAME: begin
				if (len_en_q && len_dec == '0) begin
					en_next = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			length_q <= '0;
			volume_q <= '0;
			freq_q   <= '0;
			len_en_q <= 1'b0;
			count_q  <= '0;
			rate_q   <= wcp_pkg::RATE_RESET;
		end else begin
			if (sample_rate_we) begin
				rate_q <= sample_rate;
			end
			if (cmd.commit) begin
				enable_q <= en_next;
				if (op_q == wcp_pkg::OP_WRITE) begin
					unique case (addr_q)
						wcp_pkg::ADDR_LENGTH:  length_q <= wcp_pkg::LEN_BASE - {1'b0, data_q};
						wcp_pkg::ADDR_VOLUME:  volume_q <= data_q[6:5];
						wcp_pkg::ADDR_FREQ_LO: freq_q[7:0] <= data_q;
						wcp_pkg::ADDR_FREQ_HI: freq_q[10:8] <= data_q[2:0];
						wcp_pkg::ADDR_LEN_EN:  len_en_q <= data_q != '0;
						wcp_pkg::ADDR_RESTART: count_q <= '0;
						default: ;
					endcase
				end else if (op_q == wcp_pkg::OP_FRAME) begin
					if (len_en_q) begin
						length_q <= len_dec;
					end
				end else if (op_q == wcp_pkg::OP_SAMPLE) begin
					count_q <= count_q + wcp_pkg::CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROWS; i++) begin
				wave_q[i] <= '0;
			end
		end else if (cmd.commit && op_q == wcp_pkg::OP_WRITE && wave_hit) begin
			wave_q[wave_row[RW-1:0]] <= data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rd_q  <= rd_val;
			smp_q <= (op_q == wcp_pkg::OP_SAMPLE) ? smp_val : '0;
			on_q  <= en_next;
		end
	end

	assign read_data  = rd_q;
	assign sample     = smp_q;
	assign channel_on = on_q;

endmodule

`default_nettype wire

>>> rtl/core/wcp_ctrl.sv
// controller: sequences one request at a time; sample requests go through the phase products and divider
// depends on wcp_pkg
`default_nettype none

module wcp_ctrl (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	input  wire  [wcp_pkg::OP_W-1:0]     op,
	output logic                         in_stall,
	output logic                         out_valid,
	input  wire                          out_stall,
	input  wire                          div_busy,
	output wcp_pkg::cmd_t                cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_SCALE = 3'd2;
	localparam logic [2:0] ST_LOAD  = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_next;
	logic       out_valid_q;
	logic       accept;
	logic       slot_free;

	always_comb begin
		accept    = in_valid && (state_q == ST_IDLE);
		slot_free = !out_valid_q || !out_stall;
		cmd           = '0;
		cmd.load      = accept;
		state_next    = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_next = (op == wcp_pkg::OP_SAMPLE) ? ST_MUL : ST_DONE;
				end
			end
			ST_MUL: begin
				cmd.mul    = 1'b1;
				state_next = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale  = 1'b1;
				state_next = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.div_start = 1'b1;
				state_next    = ST_DIV;
			end
			ST_DIV: begin
				if (!div_busy) begin
					state_next = ST_DONE;
				end
			end
			ST_DONE: begin
				// wait for the result register to drain
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_next;
			out_valid_q <= cmd.commit || (out_valid_q && out_stall);
		end
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/core/wave_channel_playback_top.sv
// channel    | dir | handshake          | payload
// request in | in  | in_valid/in_stall  | op, addr, data
// result out | out | out_valid/out_stall| read_data, sample, channel_on
// config     | in  | sample_rate_we     | sample_rate
//
// a sample tick steps through mul and scale (phase products) and load (divider start),
// then waits in div while the divider takes one numerator bit per cycle
// (55 + clog2(WAVE_SAMPLES+1) bits), then commits from done once the output slot is free
// all other requests go from acceptance straight to done and commit from there
// a new request is taken while the previous result still waits in the output register
// arst_n clears the channel state and the wave table; sample_rate resets to 44100
// top level of the wave channel playback block; depends on wcp_pkg, wcp_ctrl, wcp_dp
`default_nettype none

`include "wave_channel_playback_top_macros.svh"

module wave_channel_playback_top #(
	parameter int WAVE_SAMPLES = 32
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire  [wcp_pkg::OP_W-1:0]        op,
	input  wire  [wcp_pkg::ADDR_W-1:0]      addr,
	input  wire  [wcp_pkg::DATA_W-1:0]      data,
	output logic                            out_valid,
	input  wire                             out_stall,
	output logic [wcp_pkg::DATA_W-1:0]      read_data,
	output logic [wcp_pkg::SMP_W-1:0]       sample,
	output logic                            channel_on,
	input  wire                             sample_rate_we,
	input  wire  [wcp_pkg::RATE_W-1:0]      sample_rate
);

	wcp_pkg::cmd_t cmd;
	logic          div_busy;

	wcp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.op        (op),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.div_busy  (div_busy),
		.cmd       (cmd)
	);

	wcp_dp #(
		.WAVE_SAMPLES (WAVE_SAMPLES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.div_busy       (div_busy),
		.op             (op),
		.addr           (addr),
		.data           (data),
		.sample_rate_we (sample_rate_we),
		.sample_rate    (sample_rate),
		.read_data      (read_data),
		.sample         (sample),
		.channel_on     (channel_on)
	);

	`WCP_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "request accepted while busy")
	`WCP_ASSERT_NOW(a_div_blocks_input, div_busy, in_stall, "input open during division")
	`WCP_ASSERT_NOW(a_muted_when_off, out_valid && !channel_on, sample == '0, "sound while channel off")
	`WCP_ASSERT_NOW(a_read_bits, out_valid, (read_data & 8'h9E) == 8'h00, "stray read data bits")

endmodule

`default_nettype wire

>>> test/wave_channel_playback_top_tb.sv
// self-checking testbench for wave_channel_playback_top: request/result streams with random stalls
// depends on wcp_pkg and the wave_channel_playback_top rtl; predicts every result internally

module wave_channel_playback_top_tb;
	import wcp_pkg::*;

	localparam int          WAVE_ENTRIES = 32;
	localparam logic [ADDR_W-1:0] WAVE_BASE = 5'd16;
	localparam int          LIMIT_CYCLES = 600000;
	localparam int          DRAIN_CYCLES = 100;
	localparam int          PHASE_ITEMS  = 140;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} channel_request_t;

	typedef struct packed {
		logic [DATA_W-1:0] rd;
		logic [SMP_W-1:0]  smp;
		logic              on;
	} playback_result_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [OP_W-1:0]     op;
	logic [ADDR_W-1:0]   addr;
	logic [DATA_W-1:0]   data;
	logic                out_valid;
	logic                out_stall;
	logic [DATA_W-1:0]   read_data;
	logic [SMP_W-1:0]    sample;
	logic                channel_on;
	logic                sample_rate_we;
	logic [RATE_W-1:0]   sample_rate;

	// predicted channel state
	logic [SMP_W-1:0]    wave_tab [WAVE_ENTRIES];
	logic                chan_en;
	logic [LEN_W-1:0]    len_left;
	logic [VOL_W-1:0]    vol;
	logic [FREQ_W-1:0]   freq;
	logic                len_en;
	logic [CNT_W-1:0]    smp_cnt;
	logic [RATE_W-1:0]   rate_cfg;

	channel_request_t    request_q [$];
	playback_result_t    outcome_q [$];
	channel_request_t    next_req;
	playback_result_t    want;

	bit                  in_taken = 1'b0;
	int                  send_idle_pct = 0;
	int                  recv_idle_pct = 0;
	int                  hold_left = 0;
	int                  cycle_count = 0;
	int                  errors = 0;
	int                  reqs_taken = 0;
	int                  results_seen = 0;
	int                  loud_samples = 0;
	int                  rate_settings = 1;

	wave_channel_playback_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.addr           (addr),
		.data           (data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.read_data      (read_data),
		.sample         (sample),
		.channel_on     (channel_on),
		.sample_rate_we (sample_rate_we),
		.sample_rate    (sample_rate)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic log_mismatch(input string msg);
		errors++;
		if (errors <= 50)
			$display("%0t mismatch: %s", $time, msg);
	endtask

	task automatic predict_request(input channel_request_t r);
		playback_result_t res;
		logic [63:0]      num;
		logic [63:0]      den;
		logic [RATE_W-1:0] rate_eff;
		int               idx;
		int               slot;
		logic [SMP_W-1:0] lvl;
		res = '0;
		case (r.op)
		OP_WRITE: begin
			case (r.addr)
			ADDR_ENABLE:  chan_en = (r.data != 0);
			ADDR_LENGTH:  len_left = LEN_BASE - {1'b0, r.data};
			ADDR_VOLUME:  vol = r.data[6:5];
			ADDR_FREQ_LO: freq[7:0] = r.data;
			ADDR_FREQ_HI: freq[10:8] = r.data[2:0];
			ADDR_LEN_EN:  len_en = (r.data != 0);
			ADDR_RESTART: smp_cnt = '0;
			default: begin
				if (r.addr >= WAVE_BASE) begin
					slot = (int'(r.addr) - int'(WAVE_BASE)) * 2;
					wave_tab[slot] = r.data[7:4];
					wave_tab[slot + 1] = r.data[3:0];
				end
			end
			endcase
		end
		OP_READ: begin
			case (r.addr)
			ADDR_ENABLE: res.rd = {7'd0, chan_en};
			ADDR_VOLUME: res.rd = {1'b0, vol, 5'd0};
			ADDR_LEN_EN: res.rd = {7'd0, len_en};
			default:     res.rd = '0;
			endcase
		end
		OP_FRAME: begin
			if (len_en) begin
				if (len_left != 0)
					len_left--;
				if (len_left == 0)
					chan_en = 1'b0;
			end
		end
		OP_SAMPLE: begin
			// exact phase: n * clock * entries / (64 * rate * period)
			rate_eff = (rate_cfg == 0) ? 18'd1 : rate_cfg;
			num = 64'(smp_cnt) * 64'(PHASE_CLOCK) * 64'(WAVE_ENTRIES);
			den = (64'(rate_eff) * 64'(PERIOD_BASE - {1'b0, freq})) << DEN_SHIFT;
			idx = int'((num / den) % 64'(WAVE_ENTRIES));
			lvl = wave_tab[idx];
			if (vol == 0)
				lvl = '0;
			else
				lvl = lvl >> (vol - 1);
			if (!chan_en)
				lvl = '0;
			res.smp = lvl;
			smp_cnt = smp_cnt + 1;
			if (lvl != 0)
				loud_samples++;
		end
		endcase
		res.on = chan_en;
		outcome_q = {outcome_q, res};
	endtask

	// driver: a new request goes out once the previous one was taken
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_req = request_q.pop_front();
				in_valid <= 1'b1;
				op <= next_req.op;
				addr <= next_req.addr;
				data <= next_req.data;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stalls, with a long hold-off when asked
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// monitor: check results, then predict newly taken requests
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (outcome_q.size() == 0) begin
					log_mismatch("result with no request pending");
				end else begin
					want = outcome_q.pop_front();
					if (read_data !== want.rd)
						log_mismatch($sformatf("read_data got %0h want %0h", read_data, want.rd));
					if (sample !== want.smp)
						log_mismatch($sformatf("sample got %0h want %0h", sample, want.smp));
					if (channel_on !== want.on)
						log_mismatch($sformatf("channel_on got %0b want %0b", channel_on, want.on));
				end
			end
			in_taken = in_valid && !in_stall;
			if (in_taken) begin
				reqs_taken++;
				predict_request('{op: op, addr: addr, data: data});
			end
			if (sample_rate_we)
				rate_cfg = sample_rate;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("wave_channel_playback_top_tb: errors");
			$finish;
		end
	end

	task automatic queue_request(input channel_request_t r);
		request_q = {request_q, r};
	endtask

	task automatic push_req(input logic [OP_W-1:0] o, input logic [ADDR_W-1:0] a,
			input logic [DATA_W-1:0] d);
		channel_request_t r;
		r.op = o;
		r.addr = a;
		r.data = d;
		queue_request(r);
	endtask

	function automatic channel_request_t random_request();
		channel_request_t r;
		int               pick;
		r.addr = 5'($urandom_range(31));
		r.data = 8'($urandom_range(255));
		pick = $urandom_range(99);
		if (pick < 45) begin
			r.op = OP_SAMPLE;
		end else if (pick < 60) begin
			r.op = OP_FRAME;
		end else if (pick < 70) begin
			r.op = OP_READ;
			case ($urandom_range(3))
			0: r.addr = ADDR_ENABLE;
			1: r.addr = ADDR_VOLUME;
			2: r.addr = ADDR_LEN_EN;
			default: ;
			endcase
		end else begin
			r.op = OP_WRITE;
			pick = $urandom_range(99);
			if (pick < 40) begin
				r.addr = WAVE_BASE + 5'($urandom_range(15));
			end else if (pick < 52) begin
				r.addr = ADDR_ENABLE;
				// mostly switch the channel on so playback stays audible
				r.data = ($urandom_range(4) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
			end else if (pick < 60) begin
				r.addr = ADDR_VOLUME;
			end else if (pick < 68) begin
				r.addr = ADDR_FREQ_LO;
			end else if (pick < 76) begin
				r.addr = ADDR_FREQ_HI;
			end else if (pick < 83) begin
				r.addr = ADDR_LEN_EN;
				r.data = $urandom_range(1) ? 8'h00 : 8'($urandom_range(1, 255));
			end else if (pick < 90) begin
				r.addr = ADDR_LENGTH;
			end else if (pick < 95) begin
				r.addr = ADDR_RESTART;
			end else begin
				r.addr = 5'($urandom_range(7, 15));
			end
		end
		return r;
	endfunction

	task automatic wait_idle();
		while (request_q.size() != 0 || in_valid || outcome_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_rate(input logic [RATE_W-1:0] v);
		@(negedge clk);
		sample_rate_we <= 1'b1;
		sample_rate <= v;
		@(negedge clk);
		sample_rate_we <= 1'b0;
		rate_settings++;
	endtask

	task automatic run_phase(input logic [RATE_W-1:0] rate, input int send_pct,
			input int recv_pct, input bit long_hold);
		write_rate(rate);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		// set the channel up with fresh content, then mix
		push_req(OP_WRITE, ADDR_ENABLE, 8'($urandom_range(1, 255)));
		push_req(OP_WRITE, ADDR_VOLUME, {1'($urandom_range(1)), 2'($urandom_range(1, 3)),
			5'($urandom_range(31))});
		push_req(OP_WRITE, ADDR_FREQ_LO, 8'($urandom_range(255)));
		push_req(OP_WRITE, ADDR_FREQ_HI, 8'($urandom_range(255)));
		for (int k = 0; k < 16; k++)
			push_req(OP_WRITE, WAVE_BASE + 5'(k), 8'($urandom_range(255)));
		push_req(OP_WRITE, ADDR_RESTART, 8'($urandom_range(255)));
		for (int k = 21; k < PHASE_ITEMS; k++)
			queue_request(random_request());
		if (long_hold) begin
			@(posedge clk);
			hold_left = 300;
		end
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_WRITE;
		addr = '0;
		data = '0;
		out_stall = 1'b0;
		sample_rate_we = 1'b0;
		sample_rate = RATE_RESET;
		for (int k = 0; k < WAVE_ENTRIES; k++)
			wave_tab[k] = '0;
		chan_en = 1'b0;
		len_left = '0;
		vol = '0;
		freq = '0;
		len_en = 1'b0;
		smp_cnt = '0;
		rate_cfg = RATE_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed requests at the reset sample rate
		send_idle_pct = 26;
		recv_idle_pct = 47;
		push_req(OP_READ, ADDR_ENABLE, 8'h00);
		push_req(OP_READ, ADDR_VOLUME, 8'hFF);
		push_req(OP_READ, ADDR_LEN_EN, 8'h00);
		push_req(OP_READ, 5'd7, 8'hFF);
		push_req(OP_SAMPLE, 5'd31, 8'hFF);
		push_req(OP_WRITE, WAVE_BASE, 8'hFF);
		push_req(OP_WRITE, 5'd31, 8'h00);
		push_req(OP_WRITE, 5'd17, 8'hA5);
		push_req(OP_WRITE, ADDR_ENABLE, 8'h80);
		push_req(OP_WRITE, ADDR_VOLUME, 8'h20);
		push_req(OP_SAMPLE, 5'd0, 8'h00);
		push_req(OP_SAMPLE, 5'd0, 8'h00);
		push_req(OP_WRITE, ADDR_VOLUME, 8'hE0);
		push_req(OP_READ, ADDR_VOLUME, 8'h00);
		push_req(OP_SAMPLE, 5'd0, 8'h00);
		// highest frequency code; upper data bits of the high byte are dropped
		push_req(OP_WRITE, ADDR_FREQ_LO, 8'hFF);
		push_req(OP_WRITE, ADDR_FREQ_HI, 8'hFF);
		push_req(OP_SAMPLE, 5'd0, 8'h00);
		push_req(OP_SAMPLE, 5'd0, 8'h00);
		push_req(OP_WRITE, ADDR_RESTART, 8'h55);
		push_req(OP_SAMPLE, 5'd0, 8'h00);
		push_req(OP_WRITE, 5'd9, 8'hFF);
		// length of one runs out on the first frame tick
		push_req(OP_WRITE, ADDR_LEN_EN, 8'h01);
		push_req(OP_WRITE, ADDR_LENGTH, 8'hFF);
		push_req(OP_FRAME, 5'd0, 8'h00);
		push_req(OP_READ, ADDR_ENABLE, 8'h00);
		push_req(OP_FRAME, 5'd0, 8'h00);
		push_req(OP_WRITE, ADDR_LENGTH, 8'h00);
		wait_idle();

		run_phase(18'd8000, 26, 47, 1'b0);
		run_phase(18'd192000, 26, 47, 1'b0);
		run_phase(18'd0, 47, 26, 1'b0);
		run_phase(18'h3FFFF, 47, 26, 1'b0);
		run_phase(18'($urandom_range(8000, 192000)), 0, 0, 1'b1);
		run_phase(RATE_RESET, 0, 0, 1'b0);

		$display("covered %0d requests and %0d results (%0d audible samples)",
			reqs_taken, results_seen, loud_samples);
		$display("over %0d sample rate settings with mixed stall patterns", rate_settings);
		if (errors == 0) begin
			$display("wave_channel_playback_top_tb: clean");
		end else begin
			$display("wave_channel_playback_top_tb: errors");
		end
		$finish;
	end

endmodule

>>> wave_channel_playback_top.f
+incdir+rtl/core
rtl/core/wcp_pkg.sv
rtl/core/wcp_div.sv
rtl/core/wcp_dp.sv
rtl/core/wcp_ctrl.sv
rtl/core/wave_channel_playback_top.sv
test/wave_channel_playback_top_tb.sv
